[rtl/rotated_landmark_projection_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the rotated landmark projection unit
// Concurrent checks clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ROTATED_LANDMARK_PROJECTION_UNIT_ASSERT_SVH
`define ROTATED_LANDMARK_PROJECTION_UNIT_ASSERT_SVH

// same-cycle implication
`define RLP_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RLP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rlp_pkg.sv]
// ----------------------------------------------------------------------------
// rlp_pkg
// Shared constants, stream payload types and helper functions for the
// rotated landmark projection unit.
// ----------------------------------------------------------------------------
package rlp_pkg;

    // model crop size; must stay a power of two
    localparam int CROP_PIXELS = 256;
    localparam int CROP_LOG2   = $clog2(CROP_PIXELS);

    // sigmoid: one exp factor per magnitude bit, 16 quotient bits
    localparam int EXP_BITS    = 15;
    localparam int DIV_BITS    = 16;
    // clip/abs stage, exp stages, divider setup, divider steps, output stage
    localparam int PIPE_STAGES = EXP_BITS + DIV_BITS + 2;

    // exp(-1/256) in Q0.32
    localparam logic [31:0] EXP_C0 = 32'd4278222805;

    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROI_X_CENTER = 3'd0,
        CFG_ROI_Y_CENTER = 3'd1,
        CFG_ROI_WIDTH    = 3'd2,
        CFG_ROI_HEIGHT   = 3'd3,
        CFG_ROI_COS      = 3'd4,
        CFG_ROI_SIN      = 3'd5,
        CFG_LOGIT_CLIP   = 3'd6
    } cfg_index_t;

    // input payload, last field in the low bits
    typedef struct packed {
        logic [3:0]         pad;
        logic signed [15:0] presence_logit;
        logic signed [15:0] visibility_logit;
        logic signed [19:0] raw_z;
        logic signed [19:0] raw_y;
        logic signed [19:0] raw_x;
    } in_t;

    // result payload, last field in the low bits
    typedef struct packed {
        logic [15:0]        presence;
        logic [15:0]        visibility;
        logic signed [31:0] image_z;
        logic signed [31:0] image_y;
        logic signed [31:0] image_x;
    } out_t;

    // factor exp(-2^k/256) in Q0.32: repeated rounded squaring of EXP_C0
    function automatic logic [31:0] exp_factor(input int k);
        logic [63:0] c;
        c = 64'(EXP_C0);
        for (int i = 0; i < k; i++) begin
            c = (c * c + 64'h8000_0000) >> 32;
        end
        return c[31:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

[rtl/rotated_landmark_projection_unit.sv]
// ----------------------------------------------------------------------------
// rotated_landmark_projection_unit
// Maps raw landmarks from a rotated ROI crop back to normalized image
// coordinates and turns the two logits into Q0.16 probabilities. One landmark
// is taken every cycle unless the output stalls with the pipeline full.
// The latency is set by the sigmoid path: a clip stage that also picks the
// first exp factor, fourteen chained exp-factor multiplies, a divider setup
// stage, a sixteen-step restoring divider and an output stage, one step per
// stage. The projection (rotate, scale, offset, saturate) runs in the last
// four stages with the raw coordinates delayed alongside. Each stage moves on
// when it is empty or the stage after it moves, so bubbles close up and a
// stalled result holds only the full part of the pipeline. The user writes
// registers via the cfg port only while idle; the block does not check it.
// ----------------------------------------------------------------------------
`include "rotated_landmark_projection_unit_assert.svh"

module rotated_landmark_projection_unit
    import rlp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // raw_x, raw_y, raw_z, visibility_logit, presence_logit, 4 zero bits
    input  logic [95:0]           s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // image_x, image_y, image_z, visibility, presence
    output logic [127:0]          m_tdata
);

    localparam int RAW_LAST = PIPE_STAGES - 5;
    localparam int C1_ST    = PIPE_STAGES - 4;
    localparam int C2_ST    = PIPE_STAGES - 3;
    localparam int C3_ST    = PIPE_STAGES - 2;
    localparam int C4_ST    = PIPE_STAGES - 1;

    localparam int XS_W   = 29;                 // raw*256 - crop centre
    localparam int PR_W   = XS_W + 18;          // times cos/sin
    localparam int SUM_W  = PR_W + 1;
    localparam int XY_SH  = 16 + CROP_LOG2;
    localparam int RX_W   = SUM_W - XY_SH;
    localparam int SC_W   = RX_W + 19;          // times width/height
    localparam int SR_W   = SC_W - 16;
    localparam int PZ_W   = 20 + 19;
    localparam int Z_SH   = 16 + CROP_LOG2 - 8;
    localparam int ZR_W   = PZ_W - Z_SH;

    localparam logic signed [XS_W-1:0] XS_OFFSET = XS_W'(1) << (15 + CROP_LOG2);
    localparam logic [SUM_W-1:0]       XY_HALF   = SUM_W'(1) << (XY_SH - 1);
    localparam logic [SC_W-1:0]        SC_HALF   = SC_W'(1) << 15;
    localparam logic [PZ_W-1:0]        Z_HALF    = PZ_W'(1) << (Z_SH - 1);

    // ---------------- configuration ----------------
    logic signed [17:0] roi_xc_reg;
    logic signed [17:0] roi_yc_reg;
    logic [17:0]        roi_w_reg;
    logic [17:0]        roi_h_reg;
    logic signed [17:0] roi_cos_reg;
    logic signed [17:0] roi_sin_reg;
    logic [14:0]        clip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roi_xc_reg  <= 18'sd32768;
            roi_yc_reg  <= 18'sd32768;
            roi_w_reg   <= 18'd65536;
            roi_h_reg   <= 18'd65536;
            roi_cos_reg <= 18'sd65536;
            roi_sin_reg <= 18'sd0;
            clip_reg    <= 15'd25600;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ROI_X_CENTER: roi_xc_reg  <= cfg_wdata;
                CFG_ROI_Y_CENTER: roi_yc_reg  <= cfg_wdata;
                CFG_ROI_WIDTH:    roi_w_reg   <= cfg_wdata;
                CFG_ROI_HEIGHT:   roi_h_reg   <= cfg_wdata;
                CFG_ROI_COS:      roi_cos_reg <= cfg_wdata;
                CFG_ROI_SIN:      roi_sin_reg <= cfg_wdata;
                CFG_LOGIT_CLIP:   clip_reg    <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES-1:0] stage_en;
    logic [PIPE_STAGES-1:0] valid_feed;

    // a stage holds only when it and everything after it is full and stalled
    genvar i;
    generate
        for (i = 0; i < PIPE_STAGES; i++) begin : g_en
            assign stage_en[i] = ~(&valid_reg[PIPE_STAGES-1:i]) | m_tready;
        end
    endgenerate

    assign valid_feed = {valid_reg[PIPE_STAGES-2:0], s_tvalid};
    assign valid_next = (stage_en & valid_feed) | (~stage_en & valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[PIPE_STAGES-1];

    in_t s_in;
    assign s_in = s_tdata;

    // ---------------- raw coordinate delay line ----------------
    logic signed [19:0] raw_x_reg [0:RAW_LAST];
    logic signed [19:0] raw_y_reg [0:RAW_LAST];
    logic signed [19:0] raw_z_reg [0:RAW_LAST];

    generate
        for (i = 0; i <= RAW_LAST; i++) begin : g_raw
            if (i == 0) begin : g_first
                always_ff @(posedge aclk) begin
                    if (stage_en[0]) begin
                        raw_x_reg[0] <= s_in.raw_x;
                        raw_y_reg[0] <= s_in.raw_y;
                        raw_z_reg[0] <= s_in.raw_z;
                    end
                end
            end else begin : g_next
                always_ff @(posedge aclk) begin
                    if (stage_en[i]) begin
                        raw_x_reg[i] <= raw_x_reg[i-1];
                        raw_y_reg[i] <= raw_y_reg[i-1];
                        raw_z_reg[i] <= raw_z_reg[i-1];
                    end
                end
            end
        end
    endgenerate

    // ---------------- C1: centre and rotate products ----------------
    logic signed [XS_W-1:0] xs;
    logic signed [XS_W-1:0] ys;
    logic signed [PR_W-1:0] xs_cos_reg;
    logic signed [PR_W-1:0] ys_sin_reg;
    logic signed [PR_W-1:0] xs_sin_reg;
    logic signed [PR_W-1:0] ys_cos_reg;
    logic signed [19:0]     z_c1_reg;

    assign xs = XS_W'($signed({raw_x_reg[RAW_LAST], 8'd0})) - XS_OFFSET;
    assign ys = XS_W'($signed({raw_y_reg[RAW_LAST], 8'd0})) - XS_OFFSET;

    always_ff @(posedge aclk) begin
        if (stage_en[C1_ST]) begin
            xs_cos_reg <= xs * roi_cos_reg;
            ys_sin_reg <= ys * roi_sin_reg;
            xs_sin_reg <= xs * roi_sin_reg;
            ys_cos_reg <= ys * roi_cos_reg;
            z_c1_reg   <= raw_z_reg[RAW_LAST];
        end
    end

    // ---------------- C2: rotate sums, round to Q16 ----------------
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [SUM_W-1:0]        bias_x;
    logic [SUM_W-1:0]        bias_y;
    logic signed [RX_W-1:0]  rx_reg;
    logic signed [RX_W-1:0]  ry_reg;
    logic signed [19:0]      z_c2_reg;

    // round half away from zero: add half, minus one for negatives, then shift
    always_comb begin
        sum_x  = SUM_W'(xs_cos_reg) - SUM_W'(ys_sin_reg);
        sum_y  = SUM_W'(xs_sin_reg) + SUM_W'(ys_cos_reg);
        bias_x = sum_x + XY_HALF - SUM_W'(sum_x[SUM_W-1]);
        bias_y = sum_y + XY_HALF - SUM_W'(sum_y[SUM_W-1]);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[C2_ST]) begin
            rx_reg   <= $signed(bias_x[SUM_W-1:XY_SH]);
            ry_reg   <= $signed(bias_y[SUM_W-1:XY_SH]);
            z_c2_reg <= z_c1_reg;
        end
    end

    // ---------------- C3: ROI scale ----------------
    logic signed [SC_W-1:0] sx_reg;
    logic signed [SC_W-1:0] sy_reg;
    logic signed [PZ_W-1:0] sz_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[C3_ST]) begin
            sx_reg <= rx_reg * $signed({1'b0, roi_w_reg});
            sy_reg <= ry_reg * $signed({1'b0, roi_h_reg});
            sz_reg <= z_c2_reg * $signed({1'b0, roi_w_reg});
        end
    end

    // ---------------- C4: round, offset, saturate ----------------
    logic [SC_W-1:0]        bias_sx;
    logic [SC_W-1:0]        bias_sy;
    logic [PZ_W-1:0]        bias_sz;
    logic signed [SR_W-1:0] sx_rnd;
    logic signed [SR_W-1:0] sy_rnd;
    logic signed [ZR_W-1:0] sz_rnd;
    logic signed [31:0]     image_x_reg;
    logic signed [31:0]     image_y_reg;
    logic signed [31:0]     image_z_reg;

    always_comb begin
        bias_sx = sx_reg + SC_HALF - SC_W'(sx_reg[SC_W-1]);
        bias_sy = sy_reg + SC_HALF - SC_W'(sy_reg[SC_W-1]);
        bias_sz = sz_reg + Z_HALF - PZ_W'(sz_reg[PZ_W-1]);
        sx_rnd  = $signed(bias_sx[SC_W-1:16]);
        sy_rnd  = $signed(bias_sy[SC_W-1:16]);
        sz_rnd  = $signed(bias_sz[PZ_W-1:Z_SH]);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[C4_ST]) begin
            image_x_reg <= sat32(34'(sx_rnd) + 34'(roi_xc_reg));
            image_y_reg <= sat32(34'(sy_rnd) + 34'(roi_yc_reg));
            image_z_reg <= sat32(34'(sz_rnd));
        end
    end

    // ---------------- sigmoids ----------------
    logic [15:0] visibility;
    logic [15:0] presence;

    rlp_sigmoid u_vis_sigmoid (
        .aclk     (aclk),
        .stage_en (stage_en),
        .logit    (s_in.visibility_logit),
        .clip     (clip_reg),
        .prob     (visibility)
    );

    rlp_sigmoid u_pres_sigmoid (
        .aclk     (aclk),
        .stage_en (stage_en),
        .logit    (s_in.presence_logit),
        .clip     (clip_reg),
        .prob     (presence)
    );

    out_t m_out;

    always_comb begin
        m_out.image_x    = image_x_reg;
        m_out.image_y    = image_y_reg;
        m_out.image_z    = image_z_reg;
        m_out.visibility = visibility;
        m_out.presence   = presence;
    end

    assign m_tdata = m_out;

    // ---------------- assertions ----------------
    `RLP_ASSERT_IMPLY(a_ready_free, !(m_tvalid && !m_tready), s_tready, "input blocked")
    `RLP_ASSERT_IMPLY(a_stall_full, !s_tready, (&valid_reg) && !m_tready, "stall with bubble")
    `RLP_ASSERT_NEXT(a_enter_stage0, s_tvalid && s_tready, valid_reg[0], "transfer lost")

endmodule

[rtl/rlp_sigmoid.sv]
// ----------------------------------------------------------------------------
// rlp_sigmoid
// Pipelined clip and sigmoid of one Q7.8 logit to Q0.16. Clip and abs, one
// exp factor per stage, then a restoring divider with one quotient bit per
// stage. Stage s loads when stage_en[s-1] is high.
// ----------------------------------------------------------------------------
module rlp_sigmoid
    import rlp_pkg::*;
(
    input  logic                    aclk,
    input  logic [PIPE_STAGES-1:0]  stage_en,
    input  logic signed [15:0]      logit,
    input  logic [14:0]             clip,
    output logic [15:0]             prob
);

    localparam int SETUP_ST = EXP_BITS + 1;
    localparam int E_W      = 33;   // exp value, 2^32 included
    localparam int D_W      = 34;   // divisor 2^32 + e
    localparam int N_W      = 49;   // dividend e*2^16 + d/2

    logic                  neg_reg [1:PIPE_STAGES-1];
    logic [EXP_BITS-1:0]   m_reg   [1:EXP_BITS-1];
    logic [31:0]           e_reg   [1:EXP_BITS];
    logic                  one_reg [1:EXP_BITS];
    logic [N_W-1:0]        r_reg   [0:DIV_BITS-1];
    logic [D_W-1:0]        d_reg   [0:DIV_BITS-1];
    logic [DIV_BITS-1:0]   q_reg   [1:DIV_BITS];
    logic [15:0]           prob_reg;

    // ---------------- stage 1: clip, magnitude, first factor ----------------
    logic [15:0]         abs_x;
    logic [EXP_BITS-1:0] m_first;
    logic                neg_first;

    always_comb begin
        abs_x     = logit[15] ? 16'(-logit) : 16'(logit);
        m_first   = (abs_x > {1'b0, clip}) ? clip : abs_x[EXP_BITS-1:0];
        // clipped value is negative only for a nonzero bound
        neg_first = logit[15] && (clip != '0);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            m_reg[1]   <= m_first;
            neg_reg[1] <= neg_first;
            e_reg[1]   <= EXP_C0;
            one_reg[1] <= !m_first[0];
        end
    end

    genvar s;
    generate
        for (s = 2; s < PIPE_STAGES; s++) begin : g_neg
            always_ff @(posedge aclk) begin
                if (stage_en[s-1]) begin
                    neg_reg[s] <= neg_reg[s-1];
                end
            end
        end

        // ---------------- exp stages: factor for bit s-1 ----------------
        for (s = 2; s <= EXP_BITS; s++) begin : g_exp
            localparam logic [31:0] CK = exp_factor(s - 1);
            logic [63:0] prod;
            logic [63:0] prod_rnd;

            assign prod     = 64'(e_reg[s-1]) * 64'(CK);
            assign prod_rnd = prod + 64'h8000_0000;

            always_ff @(posedge aclk) begin
                if (stage_en[s-1]) begin
                    if (m_reg[s-1][s-1]) begin
                        // e == 1.0 times CK is CK exactly
                        e_reg[s]   <= one_reg[s-1] ? CK : prod_rnd[63:32];
                        one_reg[s] <= 1'b0;
                    end else begin
                        e_reg[s]   <= e_reg[s-1];
                        one_reg[s] <= one_reg[s-1];
                    end
                end
            end

            if (s < EXP_BITS) begin : g_m
                always_ff @(posedge aclk) begin
                    if (stage_en[s-1]) begin
                        m_reg[s] <= m_reg[s-1];
                    end
                end
            end
        end
    endgenerate

    // ---------------- divider setup ----------------
    logic [E_W-1:0] e_full;
    logic [D_W-1:0] d_setup;
    logic [N_W-1:0] n_setup;

    always_comb begin
        e_full  = one_reg[EXP_BITS] ? {1'b1, 32'd0} : {1'b0, e_reg[EXP_BITS]};
        d_setup = {1'b0, e_full} + {2'b01, 32'd0};
        n_setup = {e_full, 16'd0} + N_W'(d_setup[D_W-1:1]);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[SETUP_ST-1]) begin
            r_reg[0] <= n_setup;
            d_reg[0] <= d_setup;
        end
    end

    // ---------------- divider: quotient bit DIV_BITS-t at step t ----------------
    genvar t;
    generate
        for (t = 1; t <= DIV_BITS; t++) begin : g_div
            logic [N_W:0] shifted;
            logic [N_W:0] diff;
            logic         take;

            assign shifted = (N_W+1)'(d_reg[t-1]) << (DIV_BITS - t);
            assign diff    = {1'b0, r_reg[t-1]} - shifted;
            assign take    = !diff[N_W];

            if (t == 1) begin : g_q_first
                always_ff @(posedge aclk) begin
                    if (stage_en[SETUP_ST+t-1]) begin
                        q_reg[t] <= DIV_BITS'(take);
                    end
                end
            end else begin : g_q_next
                always_ff @(posedge aclk) begin
                    if (stage_en[SETUP_ST+t-1]) begin
                        q_reg[t] <= {q_reg[t-1][DIV_BITS-2:0], take};
                    end
                end
            end

            if (t < DIV_BITS) begin : g_rem
                always_ff @(posedge aclk) begin
                    if (stage_en[SETUP_ST+t-1]) begin
                        r_reg[t] <= take ? diff[N_W-1:0] : r_reg[t-1];
                        d_reg[t] <= d_reg[t-1];
                    end
                end
            end
        end
    endgenerate

    // ---------------- output: mirror for positive logits ----------------
    logic [16:0] p_comp;
    logic [15:0] prob_next;

    always_comb begin
        p_comp = 17'h1_0000 - {1'b0, q_reg[DIV_BITS]};
        if (neg_reg[PIPE_STAGES-1]) begin
            prob_next = q_reg[DIV_BITS];
        end else begin
            prob_next = p_comp[16] ? 16'hFFFF : p_comp[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[PIPE_STAGES-1]) begin
            prob_reg <= prob_next;
        end
    end

    assign prob = prob_reg;

endmodule
